FILE: src/rft_pkg.sv
// ----------------------------------------------------------------------------
// rft_pkg
// Shared widths, constants and pipeline control type for the radial falloff
// texel unit.
// ----------------------------------------------------------------------------
package rft_pkg;

  localparam int COORD_W   = 12;   // row / column index
  localparam int SIZE_W    = 13;   // sprite size register
  localparam int LEVEL_W   = 8;    // intensity byte
  localparam int FRAC_W    = 16;   // fraction bits of x, y, r^2 and r

  localparam logic [SIZE_W-1:0] SIZE_RESET = 13'd64;

  // Control travelling beside the data in each pipeline stage
  typedef struct packed {
    logic valid;   // stage holds a word
    logic kill;    // result is forced to zero
  } pipe_ctl_t;

endpackage

FILE: src/rft_texel_if.sv
// ----------------------------------------------------------------------------
// rft_texel_if
// Valid/ready channel carrying one texel position.
// ----------------------------------------------------------------------------
interface rft_texel_if;
  import rft_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] row;
  logic [COORD_W-1:0] col;

  modport source (output valid, output row, output col, input ready);
  modport sink   (input valid, input row, input col, output ready);

endinterface

FILE: src/rft_level_if.sv
// ----------------------------------------------------------------------------
// rft_level_if
// Valid/ready channel carrying one intensity byte.
// ----------------------------------------------------------------------------
interface rft_level_if;
  import rft_pkg::*;

  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] intensity;

  modport source (output valid, output intensity, input ready);
  modport sink   (input valid, input intensity, output ready);

endinterface

FILE: src/rft_div_pipe.sv
// ----------------------------------------------------------------------------
// rft_div_pipe
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Each lane computes (d * 2^16 + half) / n for d < n, giving a Q0.16 value.
// ----------------------------------------------------------------------------
module rft_div_pipe #(
  parameter int NW = 13
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic [NW-1:0]             n,
  input  logic [rft_pkg::FRAC_W-1:0] half,
  input  rft_pkg::pipe_ctl_t        in_ctl,
  input  logic [NW-1:0]             in_dx,
  input  logic [NW-1:0]             in_dy,
  output rft_pkg::pipe_ctl_t        out_ctl,
  output logic [rft_pkg::FRAC_W-1:0] out_qx,
  output logic [rft_pkg::FRAC_W-1:0] out_qy
);
  import rft_pkg::*;

  localparam int STAGES = FRAC_W;

  pipe_ctl_t          ctl_q  [STAGES];
  logic [NW-1:0]      remx_q [STAGES];
  logic [NW-1:0]      remy_q [STAGES];
  logic [FRAC_W-1:0]  qx_q   [STAGES];
  logic [FRAC_W-1:0]  qy_q   [STAGES];
  logic [FRAC_W-1:0]  low_q  [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    pipe_ctl_t         ctl_i;
    logic [NW-1:0]     remx_i, remy_i;
    logic [FRAC_W-1:0] qx_i, qy_i, low_i;
    logic [NW:0]       tx, ty;
    logic              gex, gey;

    if (g == 0) begin : g_first
      assign ctl_i  = in_ctl;
      assign remx_i = in_dx;
      assign remy_i = in_dy;
      assign qx_i   = '0;
      assign qy_i   = '0;
      assign low_i  = half;
    end else begin : g_rest
      assign ctl_i  = ctl_q[g-1];
      assign remx_i = remx_q[g-1];
      assign remy_i = remy_q[g-1];
      assign qx_i   = qx_q[g-1];
      assign qy_i   = qy_q[g-1];
      assign low_i  = low_q[g-1];
    end

    // Shift in the next dividend bit and trial-subtract the divisor
    assign tx  = {remx_i, low_i[FRAC_W-1]};
    assign ty  = {remy_i, low_i[FRAC_W-1]};
    assign gex = (tx >= {1'b0, n});
    assign gey = (ty >= {1'b0, n});

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[g] <= '0;
      end else if (en) begin
        ctl_q[g] <= ctl_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        remx_q[g] <= gex ? NW'(tx - {1'b0, n}) : NW'(tx);
        remy_q[g] <= gey ? NW'(ty - {1'b0, n}) : NW'(ty);
        qx_q[g]   <= {qx_i[FRAC_W-2:0], gex};
        qy_q[g]   <= {qy_i[FRAC_W-2:0], gey};
        low_q[g]  <= {low_i[FRAC_W-2:0], 1'b0};
      end
    end
  end

  assign out_ctl = ctl_q[STAGES-1];
  assign out_qx  = qx_q[STAGES-1];
  assign out_qy  = qy_q[STAGES-1];

endmodule

FILE: src/rft_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// rft_sqrt_pipe
// Pipelined digit-by-digit square root of r * 2^16, one root bit per stage.
// Carries r alongside for the falloff stage.
// ----------------------------------------------------------------------------
module rft_sqrt_pipe (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       en,
  input  rft_pkg::pipe_ctl_t         in_ctl,
  input  logic [rft_pkg::FRAC_W-1:0] in_r,
  output rft_pkg::pipe_ctl_t         out_ctl,
  output logic [rft_pkg::FRAC_W-1:0] out_r,
  output logic [rft_pkg::FRAC_W-1:0] out_s
);
  import rft_pkg::*;

  localparam int STAGES = FRAC_W;
  localparam int RAD_W  = 2 * FRAC_W;
  localparam int REM_W  = FRAC_W + 2;

  pipe_ctl_t          ctl_q  [STAGES];
  logic [FRAC_W-1:0]  r_q    [STAGES];
  logic [REM_W-1:0]   rem_q  [STAGES];
  logic [FRAC_W-1:0]  root_q [STAGES];
  logic [RAD_W-1:0]   rad_q  [STAGES];

  for (genvar g = 0; g < STAGES; g++) begin : g_stage
    pipe_ctl_t         ctl_i;
    logic [FRAC_W-1:0] r_i, root_i;
    logic [REM_W-1:0]  rem_i;
    logic [RAD_W-1:0]  rad_i;
    logic [REM_W+1:0]  rem_sh;
    logic [REM_W+1:0]  trial;
    logic              ge;

    if (g == 0) begin : g_first
      assign ctl_i  = in_ctl;
      assign r_i    = in_r;
      assign rem_i  = '0;
      assign root_i = '0;
      assign rad_i  = {in_r, {FRAC_W{1'b0}}};
    end else begin : g_rest
      assign ctl_i  = ctl_q[g-1];
      assign r_i    = r_q[g-1];
      assign rem_i  = rem_q[g-1];
      assign root_i = root_q[g-1];
      assign rad_i  = rad_q[g-1];
    end

    // Bring down two radicand bits and test against 4*root + 1
    assign rem_sh = {rem_i, rad_i[RAD_W-1:RAD_W-2]};
    assign trial  = (REM_W + 2)'({root_i, 2'b01});
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_q[g] <= '0;
      end else if (en) begin
        ctl_q[g] <= ctl_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_q[g]    <= r_i;
        rem_q[g]  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
        root_q[g] <= {root_i[FRAC_W-2:0], ge};
        rad_q[g]  <= {rad_i[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign out_ctl = ctl_q[STAGES-1];
  assign out_r   = r_q[STAGES-1];
  assign out_s   = root_q[STAGES-1];

endmodule

FILE: src/rft_out_skid.sv
// ----------------------------------------------------------------------------
// rft_out_skid
// Output register with one skid entry. The pipeline advances while the
// skid entry is free.
// ----------------------------------------------------------------------------
module rft_out_skid (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        last_valid,
  input  logic [rft_pkg::LEVEL_W-1:0] last_level,
  output logic                        en,
  rft_level_if.source                 level_out
);
  import rft_pkg::*;

  logic               out_valid;
  logic [LEVEL_W-1:0] out_level;
  logic               skid_valid;
  logic [LEVEL_W-1:0] skid_level;
  logic               take;

  assign take = out_valid && level_out.ready;
  assign en   = !skid_valid;

  // Control: output and skid occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!skid_valid) begin
      if (last_valid) begin
        if (!out_valid || take) begin
          out_valid <= 1'b1;
        end else begin
          skid_valid <= 1'b1;
        end
      end else if (take) begin
        out_valid <= 1'b0;
      end
    end else if (take) begin
      skid_valid <= 1'b0;
    end
  end

  // Data: load the output from the pipe or drain the skid entry
  always_ff @(posedge clk) begin
    if (!skid_valid) begin
      if (last_valid) begin
        if (!out_valid || take) begin
          out_level <= last_level;
        end else begin
          skid_level <= last_level;
        end
      end
    end else if (take) begin
      out_level <= skid_level;
    end
  end

  assign level_out.valid     = out_valid;
  assign level_out.intensity = out_level;

endmodule

FILE: src/radial_falloff_texel_unit.sv
// ----------------------------------------------------------------------------
// radial_falloff_texel_unit
// Smoothstep radial falloff of one sprite texel: position in, 8-bit level out.
//
//   channel      dir  handshake      word
//   -----------  ---  -------------  ---------------------------------
//   texel_in     in   valid/ready    row[11:0], col[11:0]
//   texel_out    out  valid/ready    intensity[7:0]
//   cfg          in   cfg_we only    cfg_wdata[12:0] = sprite_size
//
// One texel enters every cycle while texel_in.ready is high. A word passes from
// acceptance through the two 16-stage bit-per-stage units (coordinate divider
// and square root) and seven register stages to the word on texel_out.
// Synchronous reset clears all valid bits and loads sprite_size with 64.
// A stall on texel_out freezes the whole pipe only once the skid entry is
// full; texel_in.ready is that condition, and no word is lost or repeated.
// ----------------------------------------------------------------------------
module radial_falloff_texel_unit #(
  parameter int MAX_SPRITE = 4096
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rft_pkg::SIZE_W-1:0] cfg_wdata,
  rft_texel_if.sink                  texel_in,
  rft_level_if.source                texel_out
);
  import rft_pkg::*;

  localparam int NW = $clog2(MAX_SPRITE + 1);
  localparam int CW = (NW > SIZE_W) ? NW : SIZE_W;

  logic               en;
  logic [SIZE_W-1:0]  sprite_size;

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      sprite_size <= SIZE_RESET;
    end else if (cfg_we) begin
      sprite_size <= cfg_wdata;
    end
  end

  // Effective size, saturated at the largest sprite
  logic [CW-1:0] size_w;
  logic [NW-1:0] n;
  logic [FRAC_W-1:0] half;

  assign size_w = CW'(sprite_size);
  assign n      = (size_w > CW'(MAX_SPRITE)) ? NW'(MAX_SPRITE) : NW'(size_w);
  assign half   = FRAC_W'(n >> 1);

  // Stage 0: distance of the texel centre from the sprite centre, in half texels
  logic [CW-1:0] twice_r, twice_c, n_w;
  logic          outside;
  logic [NW-1:0] dx_next, dy_next;

  assign twice_r = CW'({texel_in.row, 1'b1});
  assign twice_c = CW'({texel_in.col, 1'b1});
  assign n_w     = CW'(n);
  assign outside = (n == '0) || (CW'(texel_in.row) >= n_w) || (CW'(texel_in.col) >= n_w);
  assign dx_next = (twice_r >= n_w) ? NW'(twice_r - n_w) : NW'(n_w - twice_r);
  assign dy_next = (twice_c >= n_w) ? NW'(twice_c - n_w) : NW'(n_w - twice_c);

  assign texel_in.ready = en;

  pipe_ctl_t     s0_ctl;
  logic [NW-1:0] s0_dx, s0_dy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_ctl <= '0;
    end else if (en) begin
      s0_ctl.valid <= texel_in.valid;
      s0_ctl.kill  <= outside;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_dx <= dx_next;
      s0_dy <= dy_next;
    end
  end

  // Coordinate magnitudes |x|, |y| in Q0.16
  pipe_ctl_t         dv_ctl;
  logic [FRAC_W-1:0] dv_x, dv_y;

  rft_div_pipe #(
    .NW (NW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .n       (n),
    .half    (half),
    .in_ctl  (s0_ctl),
    .in_dx   (s0_dx),
    .in_dy   (s0_dy),
    .out_ctl (dv_ctl),
    .out_qx  (dv_x),
    .out_qy  (dv_y)
  );

  // Square the coordinates
  pipe_ctl_t           sq_ctl;
  logic [2*FRAC_W-1:0] sq_xx, sq_yy;

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_ctl <= '0;
    end else if (en) begin
      sq_ctl <= dv_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sq_xx <= (2*FRAC_W)'(dv_x) * (2*FRAC_W)'(dv_x);
      sq_yy <= (2*FRAC_W)'(dv_y) * (2*FRAC_W)'(dv_y);
    end
  end

  // Sum, round to 16 fraction bits; r^2 at or above one gives zero
  logic [2*FRAC_W:0] rad_sum;
  logic [FRAC_W:0]   r_full;
  pipe_ctl_t         rs2_ctl;
  logic [FRAC_W-1:0] rs2_r;

  assign rad_sum = {1'b0, sq_xx} + {1'b0, sq_yy} + (2*FRAC_W+1)'(1 << (FRAC_W - 1));
  assign r_full  = rad_sum[2*FRAC_W:FRAC_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      rs2_ctl <= '0;
    end else if (en) begin
      rs2_ctl.valid <= sq_ctl.valid;
      rs2_ctl.kill  <= sq_ctl.kill || r_full[FRAC_W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs2_r <= r_full[FRAC_W-1:0];
    end
  end

  // Radius r = sqrt(r^2) in Q0.16
  pipe_ctl_t         sr_ctl;
  logic [FRAC_W-1:0] sr_r, sr_s;

  rft_sqrt_pipe u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_ctl  (rs2_ctl),
    .in_r    (rs2_r),
    .out_ctl (sr_ctl),
    .out_r   (sr_r),
    .out_s   (sr_s)
  );

  // Cubic term r^2 * r
  pipe_ctl_t           cu_ctl;
  logic [FRAC_W-1:0]   cu_r;
  logic [2*FRAC_W-1:0] cu_rs;

  always_ff @(posedge clk) begin
    if (rst) begin
      cu_ctl <= '0;
    end else if (en) begin
      cu_ctl <= sr_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cu_r  <= sr_r;
      cu_rs <= (2*FRAC_W)'(sr_r) * (2*FRAC_W)'(sr_s);
    end
  end

  // Falloff F = 1 - 3 r^2 + 2 r^3 in Q.32, clamped to [0, 1]
  localparam int FW = 2 * FRAC_W + 2;

  logic [FW-1:0]       f_pos, f_neg, f_diff;
  logic [FRAC_W+1:0]   r3;
  logic [2*FRAC_W:0]   f_clamped;
  pipe_ctl_t           fo_ctl;
  logic [2*FRAC_W:0]   fo_f;

  assign r3        = {2'b00, cu_r} + {1'b0, cu_r, 1'b0};
  assign f_pos     = (FW'(1) << (2*FRAC_W)) + FW'({cu_rs, 1'b0});
  assign f_neg     = {r3, {FRAC_W{1'b0}}};
  assign f_diff    = (f_pos > f_neg) ? (f_pos - f_neg) : '0;
  assign f_clamped = (f_diff > (FW'(1) << (2*FRAC_W))) ? (2*FRAC_W+1)'(1) << (2*FRAC_W)
                                                        : f_diff[2*FRAC_W:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      fo_ctl <= '0;
    end else if (en) begin
      fo_ctl <= cu_ctl;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fo_f <= f_clamped;
    end
  end

  // Scale by 255 and keep the integer part; drop to zero when killed
  localparam int PW = 2*FRAC_W + 1 + LEVEL_W;

  logic [PW-1:0]      prod;
  logic [LEVEL_W:0]   lvl_wide;
  logic [LEVEL_W-1:0] lvl_next;
  logic               lv_valid;
  logic [LEVEL_W-1:0] lv_level;

  assign prod     = {fo_f, {LEVEL_W{1'b0}}} - PW'(fo_f);
  assign lvl_wide = prod[PW-1:2*FRAC_W];
  assign lvl_next = fo_ctl.kill ? '0
                  : (lvl_wide[LEVEL_W] ? {LEVEL_W{1'b1}} : lvl_wide[LEVEL_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      lv_valid <= 1'b0;
    end else if (en) begin
      lv_valid <= fo_ctl.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lv_level <= lvl_next;
    end
  end

  // Output register and skid entry
  rft_out_skid u_out (
    .clk        (clk),
    .rst        (rst),
    .last_valid (lv_valid && en),
    .last_level (lv_level),
    .en         (en),
    .level_out  (texel_out)
  );

endmodule

FILE: bench/tb_radial_falloff_texel_unit.sv
// ----------------------------------------------------------------------------
// tb_radial_falloff_texel_unit
// Self-checking bench for the radial falloff texel unit. A short table of
// hand-picked texels and sprite sizes runs first. Random texels follow over a
// series of sprite sizes, legal and out of range. Every intensity word is
// compared in order against a typed-in level or a fixed-point falloff
// predictor. Both channels idle at random, and the sink is held off once for
// long enough to fill the pipe.
// ----------------------------------------------------------------------------
module tb_radial_falloff_texel_unit;
  timeunit 1ns;
  timeprecision 1ps;

  import rft_pkg::*;

  localparam int MAX_SPRITE     = 4096;
  localparam int HALF_PERIOD    = 2;
  localparam int RESET_CYCLES   = 5;
  localparam int IDLE_PCT       = 23;
  localparam int PHASES         = 13;
  localparam int TEXELS_PER_SET = 83;
  localparam int PAUSE_PHASE    = 2;
  localparam int PAUSE_AT       = 40;
  localparam int HOLD_AT        = 700;
  localparam int HOLD_CYCLES    = 300;
  localparam int TAIL_CYCLES    = 60;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int FROM_PREDICTOR = -1;

  typedef struct {
    logic [SIZE_W-1:0]  size;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    int                 known;   // typed-in intensity, or FROM_PREDICTOR
  } texel_case_t;

  typedef struct {
    logic [LEVEL_W-1:0] level;
    logic [COORD_W-1:0] row;
    logic [COORD_W-1:0] col;
    logic [SIZE_W-1:0]  size;
  } level_expect_t;

  logic               clk;
  logic               rst;
  logic               cfg_we;
  logic [SIZE_W-1:0]  cfg_wdata;

  rft_texel_if texel_in_if ();
  rft_level_if texel_out_if ();

  level_expect_t      levels_pending[$];
  logic [SIZE_W-1:0]  size_now;
  bit                 steady;
  int                 mismatches;
  int                 texels_fed;
  int                 words_checked;
  int                 sizes_written;
  int                 sink_accepts;
  int                 sink_hold_left;
  bit                 sink_held;
  int                 quiet_cycles;

  radial_falloff_texel_unit #(
    .MAX_SPRITE (MAX_SPRITE)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .texel_in  (texel_in_if),
    .texel_out (texel_out_if)
  );

  // Free-running clock
  always #HALF_PERIOD clk = ~clk;

  // --------------------------------------------------------------------------
  // Falloff predictor
  // --------------------------------------------------------------------------

  // Distance of a texel centre from the sprite centre, Q0.16, rounded
  function automatic longint unsigned axis_offset(input longint unsigned idx,
                                                  input longint unsigned n);
    longint unsigned span;
    longint unsigned gap;
    span = 2 * idx + 1;
    gap  = (span >= n) ? span - n : n - span;
    return (gap * 65536 + n / 2) / n;
  endfunction

  // Integer square root, one result bit per trial
  function automatic longint unsigned root_floor(input longint unsigned v);
    longint unsigned acc;
    longint unsigned trial;
    acc = 0;
    for (int b = 17; b >= 0; b--) begin
      trial = acc | (64'd1 << b);
      if (trial * trial <= v) acc = trial;
    end
    return acc;
  endfunction

  function automatic logic [LEVEL_W-1:0] falloff_level(input logic [COORD_W-1:0] row_i,
                                                       input logic [COORD_W-1:0] col_i,
                                                       input logic [SIZE_W-1:0]  size);
    longint unsigned n;
    longint unsigned dx;
    longint unsigned dy;
    longint unsigned rad2;
    longint unsigned rad;
    longint unsigned lift;
    longint unsigned drop;
    longint unsigned fall;
    longint unsigned lvl;
    n = (size > MAX_SPRITE) ? MAX_SPRITE : size;
    // Anything off the sprite, or no sprite at all, is dark
    if (n == 0 || row_i >= n || col_i >= n) return '0;
    dx   = axis_offset(row_i, n);
    dy   = axis_offset(col_i, n);
    rad2 = (dx * dx + dy * dy + 32768) >> 16;
    if (rad2 > 65536) rad2 = 65536;
    rad  = root_floor(rad2 << 16);
    if (rad > 65536) rad = 65536;
    // 1 - 3r^2 + 2r^3 in Q.32, clamped to [0, 1]
    lift = (64'd1 << 32) + 2 * rad2 * rad;
    drop = 3 * rad2 * 65536;
    fall = (lift > drop) ? lift - drop : 0;
    if (fall > (64'd1 << 32)) fall = 64'd1 << 32;
    lvl  = (255 * fall) >> 32;
    if (lvl > 255) lvl = 255;
    return lvl[LEVEL_W-1:0];
  endfunction

  // Texel index, mostly inside the sprite and sometimes anywhere
  function automatic logic [COORD_W-1:0] pick_coord(input logic [SIZE_W-1:0] size);
    int unsigned n;
    n = (size > MAX_SPRITE) ? MAX_SPRITE : size;
    if (n != 0 && $urandom_range(99) < 80) return COORD_W'($urandom_range(0, n - 1));
    return COORD_W'($urandom);
  endfunction

  // --------------------------------------------------------------------------
  // Source side
  // --------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatches++;
  endtask

  // Offer one texel, hold it until taken, then queue its expected level
  task automatic offer_texel(input logic [COORD_W-1:0] row_i,
                             input logic [COORD_W-1:0] col_i,
                             input int                 known);
    level_expect_t e;
    if (!steady && $urandom_range(99) < IDLE_PCT) begin
      texel_in_if.valid <= 1'b0;
      do @(posedge clk); while (!steady && $urandom_range(99) < IDLE_PCT);
    end
    texel_in_if.valid <= 1'b1;
    texel_in_if.row   <= row_i;
    texel_in_if.col   <= col_i;
    do @(posedge clk); while (!texel_in_if.ready);
    e.level = (known == FROM_PREDICTOR) ? falloff_level(row_i, col_i, size_now)
                                        : LEVEL_W'(known);
    e.row   = row_i;
    e.col   = col_i;
    e.size  = size_now;
    levels_pending.push_back(e);
    texels_fed++;
  endtask

  // Stop offering and wait until every queued level has come back
  task automatic drain_pipe;
    texel_in_if.valid <= 1'b0;
    while (levels_pending.size() != 0) @(posedge clk);
  endtask

  // Write the size register while the pipe is empty
  task automatic write_size(input logic [SIZE_W-1:0] value);
    drain_pipe();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
    size_now  = value;
    sizes_written++;
  endtask

  // --------------------------------------------------------------------------
  // Sink side: random back-pressure, one long hold-off, and the word check
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    level_expect_t e;
    if (rst) begin
      texel_out_if.ready <= 1'b0;
    end else begin
      if (texel_in_if.valid && texel_in_if.ready) sink_accepts++;
      // Start the long hold-off once, in the middle of a phase
      if (!sink_held && sink_accepts >= HOLD_AT) begin
        sink_held      = 1'b1;
        sink_hold_left = HOLD_CYCLES;
      end
      if (sink_hold_left > 0) begin
        texel_out_if.ready <= 1'b0;
        sink_hold_left--;
      end else begin
        texel_out_if.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
      // Compare each accepted word with the oldest expectation
      if (texel_out_if.valid && texel_out_if.ready) begin
        if (levels_pending.size() == 0) begin
          report_mismatch($sformatf("unexpected word intensity=%0d",
                                    texel_out_if.intensity));
        end else begin
          e = levels_pending.pop_front();
          words_checked++;
          if (texel_out_if.intensity !== e.level)
            report_mismatch($sformatf("size=%0d row=%0d col=%0d intensity=%0d, want %0d",
                                      e.size, e.row, e.col,
                                      texel_out_if.intensity, e.level));
        end
      end
    end
  end

  // Watchdog: end the run if no word moves on either channel for too long
  always @(posedge clk) begin
    if (rst || (texel_in_if.valid && texel_in_if.ready) ||
        (texel_out_if.valid && texel_out_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no word moved for %0d cycles, %0d levels outstanding",
               quiet_cycles, levels_pending.size());
      $display("tb_radial_falloff_texel_unit failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    texel_case_t       directed_cases[25];
    logic [SIZE_W-1:0] phase_size[PHASES];

    clk                = 1'b0;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_wdata          = '0;
    texel_in_if.valid  = 1'b0;
    texel_in_if.row    = '0;
    texel_in_if.col    = '0;
    texel_out_if.ready = 1'b0;
    size_now           = SIZE_RESET;
    steady             = 1'b0;
    mismatches         = 0;
    texels_fed         = 0;
    words_checked      = 0;
    sizes_written      = 0;
    sink_accepts       = 0;
    sink_hold_left     = 0;
    sink_held          = 1'b0;
    quiet_cycles       = 0;

    // Hand-picked texels; the size column reprograms the register on change
    directed_cases = '{
      '{13'd64,   12'd31,   12'd31,   FROM_PREDICTOR},  // reset size, near centre
      '{13'd64,   12'd0,    12'd0,    0},               // corner, outside the disc
      '{13'd64,   12'd63,   12'd63,   0},
      '{13'd64,   12'd64,   12'd0,    0},               // row at size
      '{13'd64,   12'd0,    12'd64,   0},               // column at size
      '{13'd64,   12'd4095, 12'd4095, 0},
      '{13'd64,   12'd32,   12'd0,    FROM_PREDICTOR},  // just inside the rim
      '{13'd64,   12'd10,   12'd20,   FROM_PREDICTOR},
      '{13'd1,    12'd0,    12'd0,    255},             // single-texel sprite
      '{13'd1,    12'd0,    12'd1,    0},
      '{13'd1,    12'd4095, 12'd0,    0},
      '{13'd2,    12'd0,    12'd1,    FROM_PREDICTOR},
      '{13'd2,    12'd1,    12'd1,    FROM_PREDICTOR},
      '{13'd3,    12'd1,    12'd1,    255},             // exact centre
      '{13'd3,    12'd0,    12'd1,    FROM_PREDICTOR},
      '{13'd0,    12'd0,    12'd0,    0},               // zero size
      '{13'd0,    12'd4095, 12'd4095, 0},
      '{13'd4096, 12'd2047, 12'd2048, 255},             // largest legal size
      '{13'd4096, 12'd0,    12'd4095, 0},
      '{13'd4096, 12'd4095, 12'd2047, FROM_PREDICTOR},
      '{13'd4096, 12'd1365, 12'd2730, FROM_PREDICTOR},
      '{13'd8191, 12'd2048, 12'd2047, 255},             // size saturates
      '{13'd8191, 12'd4095, 12'd4095, 0},
      '{13'd4097, 12'd2047, 12'd2047, 255},
      '{13'd5000, 12'd3000, 12'd100,  FROM_PREDICTOR}
    };

    phase_size = '{13'd64, 13'd1, 13'd2, 13'd3, 13'd4096, 13'd8191, 13'd0,
                   13'd4095, 13'd100, 13'd257, 13'd5, 13'd64, 13'd64};
    phase_size[11] = SIZE_W'($urandom_range(1, MAX_SPRITE));
    phase_size[12] = SIZE_W'($urandom_range(0, 8191));

    // Hold reset, then release it on a clock edge
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed table
    foreach (directed_cases[k]) begin
      if (directed_cases[k].size != size_now) write_size(directed_cases[k].size);
      offer_texel(directed_cases[k].row, directed_cases[k].col, directed_cases[k].known);
    end

    // Random texels over a series of sprite sizes
    for (int p = 0; p < PHASES; p++) begin
      write_size(phase_size[p]);
      // No idling on either side across the two largest sizes
      steady = (p == 4 || p == 5);
      for (int k = 0; k < TEXELS_PER_SET; k++) begin
        // Pause the source once until the pipe has emptied
        if (p == PAUSE_PHASE && k == PAUSE_AT) drain_pipe();
        offer_texel(pick_coord(size_now), pick_coord(size_now), FROM_PREDICTOR);
      end
    end
    steady = 1'b0;

    // Drain, then watch a little longer for stray words
    drain_pipe();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("run covered %0d texels over %0d size settings, %0d levels checked",
             texels_fed, sizes_written, words_checked);
    $display("sizes included zero, one, 4096 and values beyond 4096; %0d mismatches",
             mismatches);
    if (mismatches == 0) begin
      $display("tb_radial_falloff_texel_unit passed");
    end else begin
      $display("tb_radial_falloff_texel_unit failed");
    end
    $finish;
  end

endmodule
